>>> rtl/json_string_escaper_defines.svh
// Assertion macros shared by the escaper RTL.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef JSON_STRING_ESCAPER_DEFINES_SVH
`define JSON_STRING_ESCAPER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define JSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define JSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/jse_pkg.sv
// Types, character constants and helper functions for the JSON string escaper.
// Used by jse_front, jse_fifo, jse_back and json_string_escaper.
package jse_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] PRINT_LO  = 8'h20;
    localparam logic [7:0] PRINT_HI  = 8'h7e;

    // Body kind of one queued descriptor
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_PLAIN = 2'd1;
    localparam logic [1:0] KIND_PAIR  = 2'd2;
    localparam logic [1:0] KIND_UNI   = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
        logic       no_char;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
    } out_word_t;

    // One classified item: what the back end has to emit for it
    typedef struct packed {
        logic       open_quote;
        logic       close_quote;
        logic [1:0] kind;
        logic [7:0] ch;        // plain/unicode: raw byte, pair: escape letter
        logic [2:0] last_pos;  // index of the final output byte
    } esc_desc_t;

    function automatic logic [7:0] escape_sub(input logic [7:0] c);
        logic [7:0] sub;
        unique case (c)
            8'h22:   sub = CH_QUOTE;
            8'h5c:   sub = CH_BSLASH;
            8'h08:   sub = 8'h62;
            8'h0c:   sub = 8'h66;
            8'h0a:   sub = 8'h6e;
            8'h0d:   sub = 8'h72;
            8'h09:   sub = 8'h74;
            default: sub = 8'h00;
        endcase
        return sub;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] d;
        if (v < 4'd10)
            d = CH_ZERO + {4'b0000, v};
        else
            d = 8'h61 + {4'b0000, v} - 8'd10;
        return d;
    endfunction

    function automatic logic [2:0] body_len(input logic [1:0] kind);
        logic [2:0] n;
        unique case (kind)
            KIND_NONE:  n = 3'd0;
            KIND_PLAIN: n = 3'd1;
            KIND_PAIR:  n = 3'd2;
            KIND_UNI:   n = 3'd6;
            default:    n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/jse_front.sv
// Front end: accepts input words, tracks the open string, classifies the byte.
// Depends on jse_pkg and json_string_escaper_defines.svh.
`include "json_string_escaper_defines.svh"

module jse_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    output logic               text_ready,
    input  jse_pkg::in_word_t  text_word,
    output logic               push_valid,
    input  logic               push_ready,
    output jse_pkg::esc_desc_t push_desc
);

    logic       inside_reg;
    logic       inside_next;
    logic       accept;
    logic [7:0] sub;
    logic [3:0] total;

    assign text_ready = push_ready;
    assign accept     = text_valid && text_ready;
    assign sub        = jse_pkg::escape_sub(text_word.text_byte);

    always_comb
    begin
        push_desc.open_quote  = !inside_reg;
        push_desc.close_quote = text_word.end_of_text;
        push_desc.ch          = text_word.text_byte;
        if (text_word.no_char)
            push_desc.kind = jse_pkg::KIND_NONE;
        else if (sub != 8'h00)
        begin
            push_desc.kind = jse_pkg::KIND_PAIR;
            push_desc.ch   = sub;
        end
        else if (text_word.text_byte < jse_pkg::PRINT_LO
                 || text_word.text_byte > jse_pkg::PRINT_HI)
            push_desc.kind = jse_pkg::KIND_UNI;
        else
            push_desc.kind = jse_pkg::KIND_PLAIN;

        total = {3'b000, push_desc.open_quote}
              + {1'b0, jse_pkg::body_len(push_desc.kind)}
              + {3'b000, push_desc.close_quote};
        push_desc.last_pos = 3'(total - 4'd1);
    end

    // Drop an empty word inside an open string: it yields nothing
    assign push_valid = accept
                      && !(text_word.no_char && !text_word.end_of_text && inside_reg);

    always_comb
    begin
        inside_next = inside_reg;
        if (accept)
            inside_next = !text_word.end_of_text;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inside_reg <= 1'b0;
        else
            inside_reg <= inside_next;
    end

    `JSE_ASSERT_NEXT(a_close_clears, accept && text_word.end_of_text, !inside_reg,
        "string still open after a closing word")
    `JSE_ASSERT_NOW(a_push_has_bytes, push_valid && inside_reg,
        !text_word.no_char || text_word.end_of_text,
        "queued a word that yields no output")

endmodule

>>> rtl/jse_fifo.sv
// Short descriptor queue between front and back end, show-ahead read.
// Depends on jse_pkg and json_string_escaper_defines.svh.
`include "json_string_escaper_defines.svh"

module jse_fifo #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  jse_pkg::esc_desc_t push_desc,
    output logic               pop_valid,
    input  logic               pop_ready,
    output jse_pkg::esc_desc_t pop_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jse_pkg::esc_desc_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_desc   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `JSE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH),
        "queue occupancy beyond its depth")

endmodule

>>> rtl/jse_back.sv
// Back end: walks the head descriptor one output byte per cycle into a register, unless the output stalls.
// Depends on jse_pkg and json_string_escaper_defines.svh.
`include "json_string_escaper_defines.svh"

module jse_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               desc_valid,
    output logic               desc_ready,
    input  jse_pkg::esc_desc_t desc,
    output logic               json_valid,
    input  logic               json_ready,
    output jse_pkg::out_word_t json_word
);

    logic               out_valid_reg, out_valid_next;
    jse_pkg::out_word_t out_word_reg, out_word_next;
    logic [2:0]         idx_reg, idx_next;
    logic               load;
    logic               at_end;
    logic [2:0]         q;
    logic [7:0]         body_byte;
    logic [7:0]         cur_byte;

    assign load   = !out_valid_reg || json_ready;
    assign at_end = (idx_reg == desc.last_pos);
    assign q      = idx_reg - {2'b00, desc.open_quote};

    always_comb
    begin
        body_byte = desc.ch;
        unique case (desc.kind)
            jse_pkg::KIND_PAIR:
                body_byte = (q == 3'd0) ? jse_pkg::CH_BSLASH : desc.ch;
            jse_pkg::KIND_UNI:
            begin
                unique case (q)
                    3'd0:       body_byte = jse_pkg::CH_BSLASH;
                    3'd1:       body_byte = jse_pkg::CH_U;
                    3'd2, 3'd3: body_byte = jse_pkg::CH_ZERO;
                    3'd4:       body_byte = jse_pkg::hex_digit(desc.ch[7:4]);
                    default:    body_byte = jse_pkg::hex_digit(desc.ch[3:0]);
                endcase
            end
            default:
                body_byte = desc.ch;
        endcase
    end

    always_comb
    begin
        priority if (desc.open_quote && idx_reg == 3'd0)
            cur_byte = jse_pkg::CH_QUOTE;
        else if (q < jse_pkg::body_len(desc.kind))
            cur_byte = body_byte;
        else
            cur_byte = jse_pkg::CH_QUOTE;
    end

    // Pop the descriptor once its last byte moves into the output register
    assign desc_ready = load && at_end;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next = desc_valid;
            if (desc_valid)
            begin
                out_word_next.out_byte    = cur_byte;
                out_word_next.run_last    = at_end;
                out_word_next.string_done = at_end && desc.close_quote;
                idx_next                  = at_end ? 3'd0 : idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    assign json_valid = out_valid_reg;
    assign json_word  = out_word_reg;

    `JSE_ASSERT_NOW(a_idx_in_range, desc_valid, idx_reg <= desc.last_pos,
        "byte index past the end of the descriptor")
    `JSE_ASSERT_NOW(a_idx_idle, !desc_valid, idx_reg == 3'd0,
        "byte index not rewound while the queue is empty")

endmodule

>>> rtl/json_string_escaper.sv
// JSON string escaper, top level.
// Depends on jse_pkg, jse_front, jse_fifo and jse_back.
//
// Usage:
//   text channel (text_valid/text_ready/text_word) takes one word per text byte:
//   text_byte, end_of_text marks the final word of a string, no_char marks a word
//   that carries no byte (an empty string is a single word with both flags set).
//   json channel (json_valid/json_ready/json_word) gives the escaped literal one
//   byte per word; run_last flags the final byte caused by an input word and
//   string_done flags the closing quote.
// Path: an accepted word lands in the queue on the accepting edge; its bytes then
//   move one at a time from the queue head into the output register.
// Throughput: one output byte per cycle while json_ready is high, set by the
//   single byte walker in the back end. A printable byte inside an open string
//   yields one output byte; a pair escape two, a \u00xx escape six, plus one for
//   each quote added. The front keeps taking words until the descriptor queue
//   (QUEUE_DEPTH entries) fills.
// Reset: no string open, queue empty, no output word pending.
// Stall: when json_ready is low the output word holds, the walker pauses, the
//   queue fills and text_ready drops; nothing is lost or repeated.

module json_string_escaper #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    output logic               text_ready,
    input  jse_pkg::in_word_t  text_word,
    output logic               json_valid,
    input  logic               json_ready,
    output jse_pkg::out_word_t json_word
);

    // Classified words between the front and back ends
    logic               push_valid;
    logic               push_ready;
    jse_pkg::esc_desc_t push_desc;
    logic               head_valid;
    logic               head_ready;
    jse_pkg::esc_desc_t head_desc;

    // Front: track the open string and classify each byte
    jse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_word  (text_word),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    // Queue: decouple classification from byte generation
    jse_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_desc   (head_desc)
    );

    // Back: emit the quotes and escape bytes, one per cycle unless the output stalls
    jse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (head_valid),
        .desc_ready (head_ready),
        .desc       (head_desc),
        .json_valid (json_valid),
        .json_ready (json_ready),
        .json_word  (json_word)
    );

endmodule

>>> verif/json_string_escaper_tb.sv
// Self-checking testbench for json_string_escaper: feeds text words, predicts the
// escaped JSON byte stream and checks every json word against it.
// Depends on jse_pkg and the json_string_escaper RTL.
`timescale 1ns / 1ps

module json_string_escaper_tb;

    // Control bytes that get a two-character escape, and their escape letters
    localparam logic [7:0] CTRL_BS  = 8'h08;
    localparam logic [7:0] CTRL_TAB = 8'h09;
    localparam logic [7:0] CTRL_LF  = 8'h0a;
    localparam logic [7:0] CTRL_FF  = 8'h0c;
    localparam logic [7:0] CTRL_CR  = 8'h0d;
    localparam logic [7:0] LET_B    = 8'h62;
    localparam logic [7:0] LET_F    = 8'h66;
    localparam logic [7:0] LET_N    = 8'h6e;
    localparam logic [7:0] LET_R    = 8'h72;
    localparam logic [7:0] LET_T    = 8'h74;
    localparam logic [7:0] HEX_A    = 8'h61;

    localparam int HOLD_CYCLES  = 40;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 20;

    logic               clk;
    logic               rst_n;
    logic               text_valid;
    logic               text_ready;
    jse_pkg::in_word_t  text_word;
    logic               json_valid;
    logic               json_ready;
    jse_pkg::out_word_t json_word;

    json_string_escaper dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_word  (text_word),
        .json_valid (json_valid),
        .json_ready (json_ready),
        .json_word  (json_word)
    );

    // Predictor state: one bit, a string has been opened and not yet closed
    logic      string_open = 1'b0;
    // json words caused by the word being accepted, and all words still owed
    jse_pkg::out_word_t step_words[$];
    jse_pkg::out_word_t json_expected[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;
    int hold_left     = 0;

    int mismatch_count = 0;
    int words_in       = 0;
    int json_checked   = 0;
    int strings_closed = 0;

    // Directed table. Where typed is set, lit holds the exact bytes expected; run_last
    // goes on the last of them, string_done too when the word ends the string.
    typedef struct {
        logic [7:0] ch;
        logic       eot;
        logic       nc;
        bit         typed;
        string      lit;
    } text_row_t;

    localparam int N_ROWS = 23;

    text_row_t text_rows [N_ROWS] = '{
        '{8'h61, 1'b0, 1'b0, 1'b1, "\"a"},           // first word after reset opens
        '{8'h20, 1'b0, 1'b0, 1'b1, " "},             // lowest printable
        '{8'h7e, 1'b0, 1'b0, 1'b1, "~"},             // highest printable
        '{8'h1f, 1'b0, 1'b0, 1'b1, "\\u001f"},
        '{8'h7f, 1'b0, 1'b0, 1'b1, "\\u007f"},
        '{8'h00, 1'b0, 1'b0, 1'b1, "\\u0000"},
        '{8'hff, 1'b0, 1'b0, 1'b1, "\\u00ff"},
        '{8'h22, 1'b0, 1'b0, 1'b0, ""},              // quote
        '{8'h5c, 1'b0, 1'b0, 1'b0, ""},              // backslash
        '{CTRL_BS,  1'b0, 1'b0, 1'b0, ""},
        '{CTRL_FF,  1'b0, 1'b0, 1'b0, ""},
        '{CTRL_LF,  1'b0, 1'b0, 1'b0, ""},
        '{CTRL_CR,  1'b0, 1'b0, 1'b0, ""},
        '{CTRL_TAB, 1'b0, 1'b0, 1'b0, ""},
        '{8'ha5, 1'b0, 1'b1, 1'b1, ""},              // empty word inside a string
        '{8'h80, 1'b1, 1'b0, 1'b1, "\\u0080\""},
        '{8'h00, 1'b1, 1'b1, 1'b1, "\"\""},          // empty string
        '{8'h3c, 1'b0, 1'b1, 1'b1, "\""},            // empty word opens a string
        '{8'hc3, 1'b1, 1'b1, 1'b1, "\""},            // empty word closes it
        '{8'h9c, 1'b1, 1'b0, 1'b1, "\"\\u009c\""},   // eight bytes from one word
        '{8'h5a, 1'b1, 1'b0, 1'b0, ""},
        '{8'h41, 1'b0, 1'b0, 1'b0, ""},
        '{8'hff, 1'b1, 1'b1, 1'b1, "\""}
    };

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Guard against a hung block: generous against the slowest legal run
    initial
    begin
        #2_000_000;
        $display("json_string_escaper regression: fail");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function automatic void add_json(input logic [7:0] b);
        jse_pkg::out_word_t w;
        w.out_byte    = b;
        w.run_last    = 1'b0;
        w.string_done = 1'b0;
        step_words.insert(step_words.size(), w);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? (jse_pkg::CH_ZERO + 8'(nib)) : (HEX_A + 8'(nib) - 8'd10);
    endfunction

    // Predict the json words for one text word and advance the open-string bit
    function automatic void escape_word(input jse_pkg::in_word_t w);
        logic [7:0] c;
        logic [7:0] letter;
        c = w.text_byte;
        step_words.delete();
        if (!string_open)
        begin
            add_json(jse_pkg::CH_QUOTE);
            string_open = 1'b1;
        end
        if (!w.no_char)
        begin
            case (c)
                jse_pkg::CH_QUOTE:  letter = jse_pkg::CH_QUOTE;
                jse_pkg::CH_BSLASH: letter = jse_pkg::CH_BSLASH;
                CTRL_BS:            letter = LET_B;
                CTRL_FF:            letter = LET_F;
                CTRL_LF:            letter = LET_N;
                CTRL_CR:            letter = LET_R;
                CTRL_TAB:           letter = LET_T;
                default:            letter = 8'h00;
            endcase
            if (letter != 8'h00)
            begin
                add_json(jse_pkg::CH_BSLASH);
                add_json(letter);
            end
            else if (c < jse_pkg::PRINT_LO || c > jse_pkg::PRINT_HI)
            begin
                // \u00xx, lower-case hex, no UTF-8 decoding
                add_json(jse_pkg::CH_BSLASH);
                add_json(jse_pkg::CH_U);
                add_json(jse_pkg::CH_ZERO);
                add_json(jse_pkg::CH_ZERO);
                add_json(hex_char(c[7:4]));
                add_json(hex_char(c[3:0]));
            end
            else
                add_json(c);
        end
        if (w.end_of_text)
        begin
            add_json(jse_pkg::CH_QUOTE);
            step_words[step_words.size() - 1].string_done = 1'b1;
            string_open = 1'b0;
        end
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].run_last = 1'b1;
    endfunction

    // Offer one text word. Entered just after a falling edge; returns just after
    // the falling edge that follows acceptance. Valid holds until the word is taken.
    task automatic send_word(input jse_pkg::in_word_t w, input bit typed, input string lit);
        jse_pkg::out_word_t t;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            text_valid <= 1'b0;
            @(negedge clk);
        end
        text_valid <= 1'b1;
        text_word  <= w;
        do
            @(posedge clk);
        while (!text_ready);
        escape_word(w);
        // Typed rows replace the prediction with the bytes written out by hand
        if (typed)
        begin
            step_words.delete();
            for (int i = 0; i < lit.len(); i++)
            begin
                t.out_byte    = lit[i];
                t.run_last    = (i == lit.len() - 1);
                t.string_done = (i == lit.len() - 1) && w.end_of_text;
                step_words.insert(step_words.size(), t);
            end
        end
        foreach (step_words[i])
            json_expected.insert(json_expected.size(), step_words[i]);
        words_in++;
        @(negedge clk);
    endtask

    // Bias text bytes towards printable characters but hit every escape class
    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 8'($urandom_range(32'h20, 32'h7e));
        else if (r < 60)
            return ($urandom_range(0, 1) != 0) ? jse_pkg::CH_QUOTE : jse_pkg::CH_BSLASH;
        else if (r < 75)
        begin
            case ($urandom_range(0, 4))
                0:       return CTRL_BS;
                1:       return CTRL_TAB;
                2:       return CTRL_LF;
                3:       return CTRL_FF;
                default: return CTRL_CR;
            endcase
        end
        else if (r < 85)
            return 8'($urandom_range(32'h00, 32'h1f));
        else if (r < 95)
            return 8'($urandom_range(32'h7f, 32'hff));
        else
            return 8'($urandom());
    endfunction

    // One well-formed string: body words, the odd empty word, then a closing word
    task automatic send_random_string(inout int sent);
        int                len;
        jse_pkg::in_word_t w;
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 24);
        for (int i = 0; i < len; i++)
        begin
            w.text_byte   = pick_text_byte();
            w.end_of_text = 1'b0;
            w.no_char     = ($urandom_range(0, 19) == 0);
            send_word(w, 1'b0, "");
            if (!w.no_char)
                sent++;
        end
        w.text_byte   = pick_text_byte();
        w.end_of_text = 1'b1;
        w.no_char     = (len == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 4) == 0);
        send_word(w, 1'b0, "");
        sent++;
    endtask

    task automatic send_random_text(input int target);
        int sent;
        sent = 0;
        while (sent < target)
            send_random_string(sent);
    endtask

    // Drop valid and hold off until every owed json word has come back or DRAIN_LIMIT runs out
    task automatic wait_json_drained();
        int n;
        n = 0;
        text_valid <= 1'b0;
        while (json_expected.size() > 0 && n < DRAIN_LIMIT)
        begin
            @(negedge clk);
            n++;
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request that lets the
    // descriptor queue fill and push back on the text side
    initial
    begin
        json_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (!rst_n)
                json_ready <= 1'b0;
            else if (hold_left > 0)
            begin
                json_ready <= 1'b0;
                hold_left--;
            end
            else
                json_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check every accepted json word against the oldest one owed
    always @(posedge clk)
    begin
        jse_pkg::out_word_t want;
        if (rst_n && json_valid && json_ready)
        begin
            if (json_expected.size() == 0)
                note_mismatch($sformatf("unexpected json word byte=%02h run_last=%0b done=%0b",
                                        json_word.out_byte, json_word.run_last,
                                        json_word.string_done));
            else
            begin
                want = json_expected.pop_front();
                if (json_word.out_byte !== want.out_byte)
                    note_mismatch($sformatf("out_byte %02h, want %02h",
                                            json_word.out_byte, want.out_byte));
                if (json_word.run_last !== want.run_last)
                    note_mismatch($sformatf("run_last %0b, want %0b on byte %02h",
                                            json_word.run_last, want.run_last, want.out_byte));
                if (json_word.string_done !== want.string_done)
                    note_mismatch($sformatf("string_done %0b, want %0b on byte %02h",
                                            json_word.string_done, want.string_done,
                                            want.out_byte));
            end
            json_checked++;
            if (json_word.string_done === 1'b1)
                strings_closed++;
        end
    end

    initial
    begin
        text_valid = 1'b0;
        text_word  = '0;
        rst_n      = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Phase one: sender idles lightly, receiver heavily
        send_idle_pct = 22;
        recv_idle_pct = 64;
        foreach (text_rows[i])
            send_word('{text_byte: text_rows[i].ch, end_of_text: text_rows[i].eot,
                        no_char: text_rows[i].nc}, text_rows[i].typed, text_rows[i].lit);
        send_random_text(70);
        hold_req = 1'b1;
        send_random_text(80);
        wait_json_drained();

        // Phase two: the other way round
        send_idle_pct = 64;
        recv_idle_pct = 22;
        send_random_text(150);
        wait_json_drained();

        // Phase three: full rate both sides, with one more long hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_text(60);
        hold_req = 1'b1;
        send_random_text(90);
        wait_json_drained();

        // Let any stray output show up before closing the run
        repeat (TAIL_CYCLES) @(posedge clk);
        if (json_expected.size() > 0)
            note_mismatch($sformatf("%0d json words never arrived", json_expected.size()));

        $display("Covered %0d text words (%0d from the directed table), %0d json bytes, %0d strings.",
                 words_in, N_ROWS, json_checked, strings_closed);
        $display("Idle mixes 22/64, 64/22 and none; two receiver hold-offs of %0d cycles.",
                 HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("json_string_escaper regression: pass");
        else
            $display("json_string_escaper regression: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/jse_pkg.sv
rtl/jse_front.sv
rtl/jse_fifo.sv
rtl/jse_back.sv
rtl/json_string_escaper.sv
verif/json_string_escaper_tb.sv
